FILE: sv/gmcm_pkg.sv
// Shared constants and types for the mains current meter.
`default_nettype none
package gmcm_pkg;

   localparam int HIST_DEPTH   = 40;
   localparam int PHASE_COUNT  = 3;
   localparam int ACC_WIDTH    = 40;
   localparam int HIST_ENTRIES = HIST_DEPTH * PHASE_COUNT;
   localparam int HIST_AW      = $clog2(HIST_ENTRIES);
   localparam int POS_W        = $clog2(HIST_DEPTH);
   localparam int PHASE_W      = 2;
   localparam int MAG_W        = 32;
   localparam int SUM_W        = 38;
   localparam int COEF_W       = 18;
   localparam int SCALE_W      = 26;
   localparam int LEVEL_W      = 24;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 26;

   // Register indexes of the configuration port.
   localparam logic [CSR_AW-1:0] CSR_RES_COEFF = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_BIN_COS   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_BIN_SIN   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_SCALE     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_THRESH    = 3'd4;

   // Reset values of the registers.
   localparam logic signed [COEF_W-1:0] RST_RES_COEFF = 18'sd128553;
   localparam logic signed [COEF_W-1:0] RST_BIN_COS   = 18'sd64277;
   localparam logic signed [COEF_W-1:0] RST_BIN_SIN   = 18'sd12785;
   localparam logic [SCALE_W-1:0]       RST_SCALE     = 26'd9002160;
   localparam logic [LEVEL_W-1:0]       RST_THRESH    = 24'd2000;

   // Sequencer states of the top level.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_COS,
      ST_SIN,
      ST_SQR,
      ST_SQI,
      ST_ADD,
      ST_SQRT,
      ST_RD,
      ST_UPD,
      ST_SCALE,
      ST_OUT
   } gmcm_state_type;

   // Handshake between the sequencer and the square root unit.
   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } gmcm_sqrt_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] root;
   } gmcm_sqrt_rsp_type;

endpackage
`default_nettype wire

FILE: sv/gmcm_hist_ram.sv
// Magnitude history memory for all phases, with per-entry valid bits.
`default_nettype none
module gmcm_hist_ram
   import gmcm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [HIST_AW-1:0] addr,
   input  wire logic [MAG_W-1:0]   wr_data,
   output      logic [MAG_W-1:0]   rd_data
);

   logic [MAG_W-1:0]      mem [HIST_ENTRIES];
   logic [HIST_ENTRIES-1:0] valid_ff;
   logic [MAG_W-1:0]      rd_ff;
   logic                  rd_valid_ff;

   // Storage array: one write or one read per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule
`default_nettype wire

FILE: sv/gmcm_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module gmcm_isqrt
   import gmcm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gmcm_sqrt_req_type req,
   output      gmcm_sqrt_rsp_type rsp
);

   logic [63:0] rem_ff,  rem_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff,  bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   // One restoring step per cycle.
   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.radicand;
         root_in = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff[MAG_W-1:0];

endmodule
`default_nettype wire

FILE: sv/goertzel_mains_current_meter_unit.sv
// Goertzel mains current meter: resonator, block magnitude and level averaging.
// A sample that is not a block end is multiplied, then accumulated. A block end runs
// ST_STEP to ST_OUT, waiting in ST_SQRT for the square root, which it skips when the
// magnitude saturates; it ends after ST_SIN for an out-of-range phase. One item is handled
// at a time; a waiting result stalls only the next block end. Synchronous reset clears the
// filter, history valid bits, sums and ring positions and restores the register defaults.
`default_nettype none
module goertzel_mains_current_meter_unit
   import gmcm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [15:0]       req_tdata,  // [11:0] sample
   input  wire logic [1:0]        req_tuser,  // [1:0] phase
   input  wire logic              req_tlast,  // last sample of the block
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [55:0]       rsp_tdata,  // [31:0] block_magnitude, [55:32] phase_level
   output      logic [1:0]        rsp_tuser,  // [1:0] phase_out
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   gmcm_state_type state_ff, state_in;

   logic signed [COEF_W-1:0] coeff_ff, cos_ff, sin_ff;
   logic [SCALE_W-1:0]       scale_ff;
   logic [LEVEL_W-1:0]       thresh_ff;

   logic signed [ACC_WIDTH-1:0] d1_ff, d2_ff;
   logic [11:0]                 sample_ff;
   logic [PHASE_W-1:0]          phase_ff;
   logic                        last_ff;
   logic signed [57:0]          prod_ff;
   logic signed [42:0]          re_ff;
   logic signed [41:0]          im_ff;
   logic [MAG_W-1:0]            ai_ff;
   logic                        sat_ff;
   logic [63:0]                 sqr_ff, sqi_ff;
   logic [MAG_W-1:0]            mag_ff;
   logic [63:0]                 lvl_prod_ff;
   logic [SUM_W-1:0]            sum_ff [PHASE_COUNT];
   logic [POS_W-1:0]            pos_ff [PHASE_COUNT];

   logic                 rsp_valid_ff;
   logic [PHASE_W-1:0]   rsp_phase_ff;
   logic [MAG_W-1:0]     rsp_mag_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;

   logic signed [ACC_WIDTH:0] mul_a;
   logic signed [COEF_W-1:0]  mul_c;
   logic signed [57:0]        mul_p;
   logic signed [41:0]        rnd_w;
   logic signed [43:0]        fresh_w;
   logic signed [ACC_WIDTH-1:0] fresh_sat;
   logic [42:0]               ar_w;
   logic [41:0]               ai_w;
   logic [64:0]               sq_sum;
   logic [HIST_AW-1:0]        ram_addr;
   logic [MAG_W-1:0]          ram_rd;
   logic                      ram_we;
   logic [SUM_W-1:0]          sum_new;
   logic [39:0]               level_raw;
   logic [LEVEL_W-1:0]        level_w;
   logic                      accept;
   logic                      out_free;
   gmcm_sqrt_req_type         sq_req;
   gmcm_sqrt_rsp_type         sq_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff  <= RST_RES_COEFF;
         cos_ff    <= RST_BIN_COS;
         sin_ff    <= RST_BIN_SIN;
         scale_ff  <= RST_SCALE;
         thresh_ff <= RST_THRESH;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RES_COEFF: coeff_ff  <= csr_wdata[COEF_W-1:0];
            CSR_BIN_COS:   cos_ff    <= csr_wdata[COEF_W-1:0];
            CSR_BIN_SIN:   sin_ff    <= csr_wdata[COEF_W-1:0];
            CSR_SCALE:     scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_THRESH:    thresh_ff <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Shared coefficient multiplier: resonator feedback, then the cosine and sine terms.
   always_comb begin
      unique case (state_ff)
         ST_STEP: begin
            mul_a = (ACC_WIDTH+1)'(d1_ff);
            mul_c = cos_ff;
         end
         ST_COS: begin
            mul_a = (ACC_WIDTH+1)'(d2_ff);
            mul_c = sin_ff;
         end
         default: begin
            mul_a = (ACC_WIDTH+1)'(d1_ff);
            mul_c = coeff_ff;
         end
      endcase
   end
   assign mul_p = 58'(mul_a) * 58'(mul_c);

   // Round to nearest of the registered product over 2^16.
   assign rnd_w = 42'((prod_ff + 58'sd32768) >>> 16);

   // Resonator update with saturation to the accumulator range.
   assign fresh_w = 44'(rnd_w) - 44'(d2_ff) + 44'($signed({1'b0, sample_ff}));
   always_comb begin
      if (fresh_w[43:ACC_WIDTH-1] == '0 || fresh_w[43:ACC_WIDTH-1] == '1) begin
         fresh_sat = fresh_w[ACC_WIDTH-1:0];
      end else if (fresh_w[43]) begin
         fresh_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      end else begin
         fresh_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
   end

   assign ar_w   = re_ff[42] ? 43'(-re_ff) : 43'(re_ff);
   assign ai_w   = im_ff[41] ? 42'(-im_ff) : 42'(im_ff);
   assign sq_sum = {1'b0, sqr_ff} + {1'b0, sqi_ff};

   // History memory address and update.
   assign ram_addr = HIST_AW'(HIST_AW'(phase_ff) * HIST_AW'(HIST_DEPTH))
                     + HIST_AW'(pos_ff[phase_ff]);
   assign ram_we   = (state_ff == ST_UPD);
   assign sum_new  = sum_ff[phase_ff] - SUM_W'(ram_rd) + SUM_W'(mag_ff);

   // Level: saturate, then zero below threshold.
   assign level_raw = lvl_prod_ff[63:24];
   always_comb begin
      level_w = (level_raw[39:LEVEL_W] != '0) ? '1 : level_raw[LEVEL_W-1:0];
      if (level_w < thresh_ff) begin
         level_w = '0;
      end
   end

   assign sq_req.start    = (state_ff == ST_ADD) && !(sat_ff || sq_sum[64]);
   assign sq_req.radicand = sq_sum[63:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_STEP;
         ST_STEP:  state_in = last_ff ? ST_COS : ST_IDLE;
         ST_COS:   state_in = ST_SIN;
         ST_SIN:   state_in = (32'(phase_ff) < PHASE_COUNT) ? ST_SQR : ST_IDLE;
         ST_SQR:   state_in = ST_SQI;
         ST_SQI:   state_in = ST_ADD;
         ST_ADD:   state_in = sq_req.start ? ST_SQRT : ST_RD;
         ST_SQRT:  if (sq_rsp.done) state_in = ST_RD;
         ST_RD:    state_in = ST_UPD;
         ST_UPD:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Filter state and per-phase bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
         for (int p = 0; p < PHASE_COUNT; p++) begin
            sum_ff[p] <= '0;
            pos_ff[p] <= '0;
         end
      end else begin
         if (state_ff == ST_STEP) begin
            d2_ff <= d1_ff;
            d1_ff <= fresh_sat;
         end
         if (state_ff == ST_SIN) begin
            d1_ff <= '0;
            d2_ff <= '0;
         end
         if (state_ff == ST_UPD) begin
            sum_ff[phase_ff] <= sum_new;
            pos_ff[phase_ff] <= (32'(pos_ff[phase_ff]) == HIST_DEPTH - 1) ? '0
                                : pos_ff[phase_ff] + POS_W'(1);
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_tdata[11:0];
         phase_ff  <= req_tuser;
         last_ff   <= req_tlast;
      end
      prod_ff <= mul_p;
      if (state_ff == ST_COS) begin
         re_ff <= 43'(d1_ff) - 43'(rnd_w);
      end
      if (state_ff == ST_SIN) begin
         im_ff <= rnd_w;
      end
      if (state_ff == ST_SQR) begin
         ai_ff  <= ai_w[MAG_W-1:0];
         sat_ff <= (ar_w[42:MAG_W] != '0) || (ai_w[41:MAG_W] != '0);
         sqr_ff <= 64'(ar_w[MAG_W-1:0]) * 64'(ar_w[MAG_W-1:0]);
      end
      if (state_ff == ST_SQI) begin
         sqi_ff <= 64'(ai_ff) * 64'(ai_ff);
      end
      if (state_ff == ST_ADD) begin
         mag_ff <= '1;
      end
      if (state_ff == ST_SQRT && sq_rsp.done) begin
         mag_ff <= sq_rsp.root;
      end
      if (state_ff == ST_SCALE) begin
         lvl_prod_ff <= 64'(sum_ff[phase_ff]) * 64'(scale_ff);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_phase_ff <= phase_ff;
         rsp_mag_ff   <= mag_ff;
         rsp_level_ff <= level_w;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_level_ff, rsp_mag_ff};
   assign rsp_tuser  = rsp_phase_ff;

   gmcm_hist_ram u_hist_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (mag_ff),
      .rd_data (ram_rd)
   );

   gmcm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .req   (sq_req),
      .rsp   (sq_rsp)
   );

endmodule
`default_nettype wire
